// File: rtl/tmm_pkg.sv
`timescale 1ns / 1ps
// tmm_pkg: shared field widths and action codes for the tabu move memory
// no dependencies

package tmm_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 10;
  localparam int TENURE_W = 5;
  localparam int HELD_W   = 5;

  localparam logic [TENURE_W-1:0] TENURE_RESET = 5'd7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CHECK  = 2'd0,
    ACT_FORBID = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_SPARE  = 2'd3
  } action_e;

endpackage

// File: rtl/tmm_list_match.sv
`timescale 1ns / 1ps
// tmm_list_match: parallel compare of one key against the live slots of the ring
// depends on nothing beyond its parameters

module tmm_list_match #(
  parameter int LIST_DEPTH = 16,
  parameter int KEY_W      = 20,
  parameter int SLOT_W     = 4,
  parameter int CNT_W      = 5
) (
  input  logic [KEY_W-1:0]  entries_i [LIST_DEPTH],
  input  logic [SLOT_W-1:0] oldest_i,
  input  logic [CNT_W-1:0]  held_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              hit_o
);

  localparam int SpanW = CNT_W + 1;

  logic [LIST_DEPTH-1:0] match;

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      logic [SpanW-1:0] pos;
      logic [SpanW-1:0] old;
      logic [SpanW-1:0] span;
      pos = SpanW'(i);
      old = SpanW'(oldest_i);
      if (pos >= old) begin
        span = pos - old;
      end else begin
        span = pos + SpanW'(LIST_DEPTH) - old;
      end
      match[i] = (span < SpanW'(held_i)) && (entries_i[i] == key_i);
    end
  end

  assign hit_o = |match;

endmodule

// File: rtl/tabu_move_memory_unit.sv
`timescale 1ns / 1ps
// tabu_move_memory_unit: fifo tabu list of recent move pairs with check, forbid and clear
// depends on tmm_pkg and tmm_list_match
//
//  channel   handshake             payload
//  ------    ---------             -------
//  command   start / busy          action_i, move_first_i, move_second_i
//  result    done_o strobe         allowed_o, entries_held_o
//  config    tenure_we_i           tenure_i
//
// a transaction is taken on any cycle; busy is never raised
// its result strobes from the result register after start passes one input register, then the
// parallel compare across all list slots and the ring pointer update
// reset clears the list, the ring pointer and the strobe and sets tenure to 7
// the receiver cannot stall, so results are simply presented for one cycle

module tabu_move_memory_unit
  import tmm_pkg::*;
#(
  parameter int LIST_DEPTH    = 16,
  parameter int POSITION_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [POS_W-1:0]    move_first_i,
  input  logic [POS_W-1:0]    move_second_i,
  output logic                done_o,
  output logic                allowed_o,
  output logic [HELD_W-1:0]   entries_held_o,
  input  logic                tenure_we_i,
  input  logic [TENURE_W-1:0] tenure_i
);

  localparam int KeyW  = 2 * POSITION_BITS;
  localparam int SlotW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CntW  = $clog2(LIST_DEPTH + 1);
  localparam int SumW  = CntW + 1;

  logic [POSITION_BITS-1:0] first_pos;
  logic [POSITION_BITS-1:0] second_pos;

  if (POSITION_BITS <= POS_W) begin : g_trunc
    assign first_pos  = move_first_i[POSITION_BITS-1:0];
    assign second_pos = move_second_i[POSITION_BITS-1:0];
  end else begin : g_ext
    assign first_pos  = POSITION_BITS'(move_first_i);
    assign second_pos = POSITION_BITS'(move_second_i);
  end

  // input register
  logic                valid_q;
  logic [ACTION_W-1:0] action_q;
  logic [KeyW-1:0]     key_q;

  // list state
  logic [KeyW-1:0]     entries_q [LIST_DEPTH];
  logic [CntW-1:0]     held_q, held_d;
  logic [SlotW-1:0]    oldest_q, oldest_d;
  logic [TENURE_W-1:0] tenure_q;

  // result register
  logic                done_q;
  logic                allowed_q;
  logic [HELD_W-1:0]   entries_held_q;

  logic                hit;
  logic                absent;
  logic                do_write;
  logic [CntW-1:0]     limit;
  logic [SumW-1:0]     slot_sum;
  logic [SlotW-1:0]    wr_slot;

  assign busy = 1'b0;

  tmm_list_match #(
    .LIST_DEPTH (LIST_DEPTH),
    .KEY_W      (KeyW),
    .SLOT_W     (SlotW),
    .CNT_W      (CntW)
  ) u_match (
    .entries_i (entries_q),
    .oldest_i  (oldest_q),
    .held_i    (held_q),
    .key_i     (key_q),
    .hit_o     (hit)
  );

  assign absent   = !hit;
  assign do_write = valid_q && (action_q == ACT_FORBID) && absent;

  always_comb begin
    if (tenure_q == '0) begin
      limit = CntW'(1);
    end else if (int'(tenure_q) > LIST_DEPTH) begin
      limit = CntW'(LIST_DEPTH);
    end else begin
      limit = CntW'(tenure_q);
    end
  end

  // slot just past the young end of the ring
  always_comb begin
    slot_sum = SumW'(oldest_q) + SumW'(held_q);
    if (slot_sum >= SumW'(LIST_DEPTH)) begin
      slot_sum = slot_sum - SumW'(LIST_DEPTH);
    end
    wr_slot = SlotW'(slot_sum);
  end

  always_comb begin
    held_d   = held_q;
    oldest_d = oldest_q;
    if (valid_q) begin
      case (action_q)
        ACT_FORBID: begin
          if (absent) begin
            if (held_q < limit) begin
              held_d = held_q + CntW'(1);
            end else if (int'(oldest_q) == LIST_DEPTH - 1) begin
              oldest_d = '0;
            end else begin
              oldest_d = oldest_q + SlotW'(1);
            end
          end
        end
        ACT_CLEAR: begin
          held_d   = '0;
          oldest_d = '0;
        end
        default: begin
          held_d   = held_q;
          oldest_d = oldest_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      held_q   <= '0;
      oldest_q <= '0;
      tenure_q <= TENURE_RESET;
      done_q   <= 1'b0;
    end else begin
      valid_q  <= start && !busy;
      held_q   <= held_d;
      oldest_q <= oldest_d;
      done_q   <= valid_q;
      if (tenure_we_i) begin
        tenure_q <= tenure_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      action_q <= action_i;
      key_q    <= {first_pos, second_pos};
    end
    if (do_write) begin
      entries_q[wr_slot] <= key_q;
    end
    if (valid_q) begin
      allowed_q      <= absent;
      entries_held_q <= HELD_W'(held_d);
    end
  end

  assign done_o         = done_q;
  assign allowed_o      = allowed_q;
  assign entries_held_o = entries_held_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for tabu_move_memory_unit, with its own tabu list predictor
// depends on tmm_pkg and the tabu_move_memory_unit rtl

module testbench;
  import tmm_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int PAIR_POOL   = 40;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    action_e          act;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] second;
  } move_cmd_t;

  typedef struct packed {
    logic              allowed;
    logic [HELD_W-1:0] held;
  } verdict_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] action_i       = ACT_CHECK;
  logic [POS_W-1:0]    move_first_i   = '0;
  logic [POS_W-1:0]    move_second_i  = '0;
  logic                done_o;
  logic                allowed_o;
  logic [HELD_W-1:0]   entries_held_o;
  logic                tenure_we_i    = 1'b0;
  logic [TENURE_W-1:0] tenure_i       = TENURE_RESET;

  // predictor state
  logic [2*POS_W-1:0]  tabu_ring [LIST_DEPTH];
  int unsigned         ring_held   = 0;
  int unsigned         ring_oldest = 0;
  logic [TENURE_W-1:0] tenure_cfg  = TENURE_RESET;

  move_cmd_t           pending_moves[$];
  verdict_t            expected_verdicts[$];
  move_cmd_t           on_port;
  logic [POS_W-1:0]    pool_first  [PAIR_POOL];
  logic [POS_W-1:0]    pool_second [PAIR_POOL];
  bit                  gapless     = 1'b0;
  int unsigned         fault_cnt   = 0;
  int unsigned         idle_cycles = 0;

  tabu_move_memory_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .move_first_i   (move_first_i),
    .move_second_i  (move_second_i),
    .done_o         (done_o),
    .allowed_o      (allowed_o),
    .entries_held_o (entries_held_o),
    .tenure_we_i    (tenure_we_i),
    .tenure_i       (tenure_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic verdict_t apply_move(move_cmd_t c);
    logic [2*POS_W-1:0] key;
    bit                 absent;
    int unsigned        lim;
    verdict_t           v;
    key    = {c.first, c.second};
    absent = 1'b1;
    for (int unsigned k = 0; k < ring_held && k < LIST_DEPTH; k++) begin
      if (tabu_ring[(ring_oldest + k) % LIST_DEPTH] == key) absent = 1'b0;
    end
    lim = (tenure_cfg == 0) ? 1 : (tenure_cfg > LIST_DEPTH) ? LIST_DEPTH : tenure_cfg;
    if (c.act == ACT_FORBID && absent) begin
      tabu_ring[(ring_oldest + ring_held) % LIST_DEPTH] = key;
      if (ring_held < lim) ring_held++;
      else ring_oldest = (ring_oldest + 1) % LIST_DEPTH;
    end else if (c.act == ACT_CLEAR) begin
      ring_held   = 0;
      ring_oldest = 0;
    end
    v.allowed = absent;
    v.held    = ring_held[HELD_W-1:0];
    return v;
  endfunction

  function automatic move_cmd_t make_move(action_e a, int unsigned f, int unsigned s);
    move_cmd_t c;
    c.act    = a;
    c.first  = f[POS_W-1:0];
    c.second = s[POS_W-1:0];
    return c;
  endfunction

  function automatic void enqueue_move(move_cmd_t c);
    pending_moves.insert(pending_moves.size(), c);
  endfunction

  // mostly pairs from a small pool so that hits and duplicates are common
  function automatic move_cmd_t random_move();
    move_cmd_t   c;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    if (roll < 3) c.act = ACT_CLEAR;
    else if (roll < 10) c.act = ACT_SPARE;
    else if (roll < 57) c.act = ACT_FORBID;
    else c.act = ACT_CHECK;
    if ($urandom_range(99) < 70) begin
      pick     = $urandom_range(PAIR_POOL - 1);
      c.first  = pool_first[pick];
      c.second = pool_second[pick];
    end else begin
      c.first  = POS_W'($urandom_range(1023));
      c.second = POS_W'($urandom_range(1023));
    end
    return c;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        expected_verdicts.insert(expected_verdicts.size(), apply_move(on_port));
      if (!start || !busy) begin
        if (pending_moves.size() != 0 && (gapless || $urandom_range(99) >= 32)) begin
          on_port       = pending_moves.pop_front();
          start         <= 1'b1;
          action_i      <= on_port.act;
          move_first_i  <= on_port.first;
          move_second_i <= on_port.second;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        if (fault_cnt < 10)
          $display("unexpected result: allowed %0d held %0d", allowed_o, entries_held_o);
        fault_cnt++;
      end else begin
        want = expected_verdicts.pop_front();
        if (allowed_o !== want.allowed || entries_held_o !== want.held) begin
          if (fault_cnt < 10)
            $display("mismatch: allowed exp %0d got %0d, held exp %0d got %0d",
                     want.allowed, allowed_o, want.held, entries_held_o);
          fault_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tabu_move_memory_unit verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_moves.size() != 0 || start || expected_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_tenure(int unsigned v);
    @(posedge clk_i);
    tenure_we_i <= 1'b1;
    tenure_i    <= v[TENURE_W-1:0];
    @(posedge clk_i);
    tenure_we_i <= 1'b0;
    tenure_cfg  = v[TENURE_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic random_phase(int unsigned tenure_val, int unsigned n, bit no_gaps);
    write_tenure(tenure_val);
    gapless = no_gaps;
    repeat (n) enqueue_move(random_move());
    wait_drained();
    gapless = 1'b0;
  endtask

  initial begin
    pool_first[0]  = '0;
    pool_second[0] = '0;
    pool_first[1]  = '1;
    pool_second[1] = '1;
    for (int i = 2; i < PAIR_POOL; i++) begin
      pool_first[i]  = POS_W'($urandom_range(1023));
      pool_second[i] = POS_W'($urandom_range(1023));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list, duplicates, spare code, clear, eviction at reset tenure
    enqueue_move(make_move(ACT_CHECK, 0, 0));
    enqueue_move(make_move(ACT_FORBID, 0, 0));
    enqueue_move(make_move(ACT_FORBID, 0, 0));
    enqueue_move(make_move(ACT_CHECK, 0, 0));
    enqueue_move(make_move(ACT_SPARE, 0, 0));
    enqueue_move(make_move(ACT_FORBID, 1023, 1023));
    enqueue_move(make_move(ACT_FORBID, 1023, 0));
    enqueue_move(make_move(ACT_FORBID, 0, 1023));
    enqueue_move(make_move(ACT_CHECK, 1023, 1023));
    enqueue_move(make_move(ACT_CLEAR, 1023, 0));
    enqueue_move(make_move(ACT_CHECK, 1023, 0));
    for (int k = 1; k <= 8; k++)
      enqueue_move(make_move(ACT_FORBID, k, 1023 - k));
    enqueue_move(make_move(ACT_CHECK, 1, 1022));
    enqueue_move(make_move(ACT_CHECK, 8, 1015));
    enqueue_move(make_move(ACT_SPARE, 2, 1021));
    enqueue_move(make_move(ACT_CLEAR, 5, 5));
    wait_drained();

    // full depth, then tenure lowered below the held count
    random_phase(16, 90, 1'b0);
    random_phase(3, 60, 1'b0);
    random_phase(0, 40, 1'b0);
    random_phase(31, 60, 1'b1);
    random_phase(17, 50, 1'b0);
    random_phase(1, 40, 1'b0);
    random_phase(5, 90, 1'b0);

    repeat (8) @(posedge clk_i);
    if (fault_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("tabu_move_memory_unit verification clean");
    end else begin
      $display("tabu_move_memory_unit verification failed");
    end
    $finish;
  end

endmodule
